// ===== hw/rtl/afc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, constants and helpers for the box frustum cull unit.
// ----------------------------------------------------------------------------
package afc_pkg;

  // Number format defaults: signed fixed point, Q16.16.
  localparam int COORD_W_DEF = 32;
  localparam int FRAC_DEF    = 16;

  // Each register half holds one value in a 32-bit slot.
  localparam int SLOT_W = 32;
  localparam int CFG_W  = 2 * SLOT_W;

  // Intermediate sums saturate at signed 48 bits.
  localparam int SUM_W  = 48;
  // Wide enough for any product or sum before saturation.
  localparam int WIDE_W = 96;

  // Configuration register file.
  localparam int NUM_REGS  = 8;
  localparam int REG_SEL_W = $clog2(NUM_REGS);
  localparam int REG_IDX_W = REG_SEL_W + 1;

  // Pipeline depth, including the output register.
  localparam int STAGES = 6;

  // Outcode bits.
  localparam logic [5:0] OC_XPOS = 6'h01;
  localparam logic [5:0] OC_YPOS = 6'h02;
  localparam logic [5:0] OC_XNEG = 6'h04;
  localparam logic [5:0] OC_YNEG = 6'h08;
  localparam logic [5:0] OC_NEAR = 6'h10;
  localparam logic [5:0] OC_FAR  = 6'h20;
  localparam logic [5:0] OC_ALL  = 6'h3F;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_MAT_I_XY   = 3'd0,
    REG_MAT_IZ_JX  = 3'd1,
    REG_MAT_J_YZ   = 3'd2,
    REG_MAT_K_XY   = 3'd3,
    REG_MAT_KZ_LX  = 3'd4,
    REG_MAT_L_YZ   = 3'd5,
    REG_ZOOM_XY    = 3'd6,
    REG_CLIP_RANGE = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VIS_OUTSIDE = 2'd0,
    VIS_PARTIAL = 2'd1,
    VIS_INSIDE  = 2'd2
  } vis_e;

  // Clamp a wide signed value to the signed 48-bit range.
  function automatic sum_t sat_sum(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-SUM_W:0] top;
    top = v[WIDE_W-1:SUM_W-1];
    if (top == '0 || top == '1) begin
      return v[SUM_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SUM_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aabb_frustum_cull_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_frustum_cull_unit
// Transforms the eight corners of a box, forms clip outcodes and classifies
// the box as wholly outside, partly inside or wholly inside the frustum.
// ----------------------------------------------------------------------------
// Each accepted input beat passes through every stage register to its result beat.
// Throughput: one box per cycle unless the output stalls; every stage is a register
// with its own valid. A stalled output holds only the stages behind it that are
// full; bubbles collapse, so the input keeps taking beats while any stage is empty.
// Reset clears all valid bits and sets every configuration register to zero.
module aabb_frustum_cull_unit #(
  parameter int COORD_WIDTH = afc_pkg::COORD_W_DEF,
  parameter int FRAC_BITS   = afc_pkg::FRAC_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [afc_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  logic [afc_pkg::CFG_W-1:0]      cfg_data_i,
  // Box input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             box_min_x_i,
  input  logic signed [31:0]             box_min_y_i,
  input  logic signed [31:0]             box_min_z_i,
  input  logic signed [31:0]             box_max_x_i,
  input  logic signed [31:0]             box_max_y_i,
  input  logic signed [31:0]             box_max_z_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     visibility_o
);
  import afc_pkg::*;

  localparam int P1W    = 2 * COORD_WIDTH;
  localparam int HALF_W = SUM_W / 2;
  localparam int PHW    = (SUM_W - HALF_W) + COORD_WIDTH;
  localparam int PLW    = HALF_W + 1 + COORD_WIDTH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_q [NUM_REGS];

  assign cfg_ready_o = 1'b1;

  // Writes to an index beyond the register file are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o &&
                 cfg_index_i[REG_IDX_W-1:REG_SEL_W] == '0) begin
      cfg_q[cfg_index_i[REG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // Unpack register halves into signed values.
  logic signed [COORD_WIDTH-1:0] mat [3][3];
  logic signed [COORD_WIDTH-1:0] trans [3];
  logic signed [COORD_WIDTH-1:0] zoom_x, zoom_y, clip_near, clip_far;

  assign mat[0][0] = cfg_q[REG_MAT_I_XY][COORD_WIDTH-1:0];
  assign mat[0][1] = cfg_q[REG_MAT_I_XY][SLOT_W +: COORD_WIDTH];
  assign mat[0][2] = cfg_q[REG_MAT_IZ_JX][COORD_WIDTH-1:0];
  assign mat[1][0] = cfg_q[REG_MAT_IZ_JX][SLOT_W +: COORD_WIDTH];
  assign mat[1][1] = cfg_q[REG_MAT_J_YZ][COORD_WIDTH-1:0];
  assign mat[1][2] = cfg_q[REG_MAT_J_YZ][SLOT_W +: COORD_WIDTH];
  assign mat[2][0] = cfg_q[REG_MAT_K_XY][COORD_WIDTH-1:0];
  assign mat[2][1] = cfg_q[REG_MAT_K_XY][SLOT_W +: COORD_WIDTH];
  assign mat[2][2] = cfg_q[REG_MAT_KZ_LX][COORD_WIDTH-1:0];
  assign trans[0]  = cfg_q[REG_MAT_KZ_LX][SLOT_W +: COORD_WIDTH];
  assign trans[1]  = cfg_q[REG_MAT_L_YZ][COORD_WIDTH-1:0];
  assign trans[2]  = cfg_q[REG_MAT_L_YZ][SLOT_W +: COORD_WIDTH];
  assign zoom_x    = cfg_q[REG_ZOOM_XY][COORD_WIDTH-1:0];
  assign zoom_y    = cfg_q[REG_ZOOM_XY][SLOT_W +: COORD_WIDTH];
  assign clip_near = cfg_q[REG_CLIP_RANGE][COORD_WIDTH-1:0];
  assign clip_far  = cfg_q[REG_CLIP_RANGE][SLOT_W +: COORD_WIDTH];

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic [STAGES-1:0] v_q, v_d, en;

  always_comb begin
    en[STAGES-1] = !v_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < STAGES; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[STAGES-1];

  // --------------------------------------------------------------------------
  // Stage 1: matrix entry times box coordinate, [side][row][column].
  // --------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] coord [2][3];
  logic signed [P1W-1:0]         prod1_q [2][3][3];

  assign coord[0][0] = box_min_x_i[COORD_WIDTH-1:0];
  assign coord[0][1] = box_min_y_i[COORD_WIDTH-1:0];
  assign coord[0][2] = box_min_z_i[COORD_WIDTH-1:0];
  assign coord[1][0] = box_max_x_i[COORD_WIDTH-1:0];
  assign coord[1][1] = box_max_y_i[COORD_WIDTH-1:0];
  assign coord[1][2] = box_max_z_i[COORD_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int s = 0; s < 2; s++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            prod1_q[s][r][c] <= P1W'(mat[r][c] * coord[s][r]);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale down, saturate, and add the translation on the diagonal.
  // --------------------------------------------------------------------------
  sum_t term2_d [2][3][3];
  sum_t term2_q [2][3][3];

  always_comb begin
    logic signed [P1W-1:0] shifted;
    sum_t                  base;
    for (int s = 0; s < 2; s++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          shifted = prod1_q[s][r][c] >>> FRAC_BITS;
          base    = sat_sum(WIDE_W'(shifted));
          if (r == c) begin
            term2_d[s][r][c] = sat_sum(WIDE_W'(base) + WIDE_W'(trans[r]));
          end else begin
            term2_d[s][r][c] = base;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      term2_q <= term2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: zoom products of the x and y terms, split into two partial
  // products on the upper and lower halves of the 48-bit term.
  // --------------------------------------------------------------------------
  logic signed [PHW-1:0] phi_q [2][3][2];
  logic signed [PLW-1:0] plo_q [2][3][2];
  sum_t                  zterm3_q [2][3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int s = 0; s < 2; s++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 2; c++) begin
            phi_q[s][r][c] <= PHW'($signed(term2_q[s][r][c][SUM_W-1:HALF_W]) *
                                   ((c == 0) ? zoom_x : zoom_y));
            plo_q[s][r][c] <= PLW'($signed({1'b0, term2_q[s][r][c][HALF_W-1:0]}) *
                                   ((c == 0) ? zoom_x : zoom_y));
          end
          zterm3_q[s][r] <= term2_q[s][r][2];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: join the partial products, scale down and saturate.
  // --------------------------------------------------------------------------
  sum_t term4_d [2][3][3];
  sum_t term4_q [2][3][3];

  always_comb begin
    logic signed [WIDE_W-1:0] full;
    for (int s = 0; s < 2; s++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 2; c++) begin
          full = (WIDE_W'(phi_q[s][r][c]) <<< HALF_W) + WIDE_W'(plo_q[s][r][c]);
          term4_d[s][r][c] = sat_sum(full >>> FRAC_BITS);
        end
        term4_d[s][r][2] = zterm3_q[s][r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      term4_q <= term4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: corner coordinates. Corner bit 0 picks the x side, bit 1 the
  // y side and bit 2 the z side of the box.
  // --------------------------------------------------------------------------
  sum_t corner_d [8][3];
  sum_t corner_q [8][3];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      for (int c = 0; c < 3; c++) begin
        corner_d[i][c] = sat_sum(WIDE_W'(term4_q[i % 2][0][c]) +
                                 WIDE_W'(term4_q[(i / 2) % 2][1][c]) +
                                 WIDE_W'(term4_q[(i / 4) % 2][2][c]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      corner_q <= corner_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: outcodes, their AND and OR over the corners, and the verdict.
  // --------------------------------------------------------------------------
  vis_e vis_d, vis_q;

  always_comb begin
    logic [5:0]              code;
    logic [5:0]              and_code;
    logic [5:0]              or_code;
    logic signed [SUM_W:0]   x_ext, y_ext, z_neg;
    sum_t                    z;
    and_code = OC_ALL;
    or_code  = '0;
    for (int i = 0; i < 8; i++) begin
      z     = corner_q[i][2];
      x_ext = (SUM_W+1)'(corner_q[i][0]);
      y_ext = (SUM_W+1)'(corner_q[i][1]);
      z_neg = -((SUM_W+1)'(z));
      code  = '0;
      if (corner_q[i][0] > z) begin
        code = code | OC_XPOS;
      end else if (x_ext < z_neg) begin
        code = code | OC_XNEG;
      end
      if (corner_q[i][1] > z) begin
        code = code | OC_YPOS;
      end else if (y_ext < z_neg) begin
        code = code | OC_YNEG;
      end
      if (z < SUM_W'(clip_near)) begin
        code = code | OC_NEAR;
      end else if (z > SUM_W'(clip_far)) begin
        code = code | OC_FAR;
      end
      and_code = and_code & code;
      or_code  = or_code | code;
    end
    if (and_code != '0) begin
      vis_d = VIS_OUTSIDE;
    end else if (or_code == '0) begin
      vis_d = VIS_INSIDE;
    end else begin
      vis_d = VIS_PARTIAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      vis_q <= vis_d;
    end
  end

  assign visibility_o = vis_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // The input is held off only when every stage holds a box.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled while a pipeline stage was empty");

  // An accepted box always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted box did not enter the first stage");

  // The full stage before the output stage keeps its box while it cannot move.
  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[STAGES-2] && !en[STAGES-1]) |=> v_q[STAGES-2])
    else $error("blocked stage dropped its box");

  // A delivered result is not repeated when nothing follows it.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v_q[STAGES-2]) |=> !out_valid_o)
    else $error("result repeated after delivery");
`endif

endmodule
`default_nettype wire

// ===== test/aabb_frustum_cull_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_unit_tb
// Streams boxes through the cull unit under several view setups and idling
// patterns, predicts each box's visibility class and checks every result.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_unit_tb;
  import afc_pkg::*;

  typedef logic signed [95:0] wide_t;
  typedef logic signed [47:0] q48_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } box_t;

  typedef enum int {
    VIEW_PLAIN,
    VIEW_SKEWED,
    VIEW_ZOOMED
  } view_kind_e;

  localparam wide_t              Q48_MAX     = 96'sh7FFF_FFFF_FFFF;
  localparam wide_t              Q48_MIN     = -96'sh8000_0000_0000;
  localparam logic signed [31:0] ONE         = 32'sh0001_0000;
  localparam logic signed [31:0] FIX_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FIX_MIN     = 32'sh8000_0000;
  localparam int                 HOLD_CYCLES = 150;
  localparam int                 RAND_BOXES  = 110;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [31:0]   box_min_x_i;
  logic signed [31:0]   box_min_y_i;
  logic signed [31:0]   box_min_z_i;
  logic signed [31:0]   box_max_x_i;
  logic signed [31:0]   box_max_y_i;
  logic signed [31:0]   box_max_z_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           visibility_o;

  // Our copy of the view registers, updated on each write beat inside the register file.
  logic [CFG_W-1:0] view_regs [NUM_REGS];
  vis_e             expected_vis_q [$];

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_req;
  int err_count;
  int boxes_sent;
  int views_used;
  int stall_offers;
  int class_count [3];

  aabb_frustum_cull_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .box_min_x_i  (box_min_x_i),
    .box_min_y_i  (box_min_y_i),
    .box_min_z_i  (box_min_z_i),
    .box_max_x_i  (box_max_x_i),
    .box_max_y_i  (box_max_y_i),
    .box_max_z_i  (box_max_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .visibility_o (visibility_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Clamp a wide signed value to the signed 48-bit range.
  function automatic q48_t clamp_q48(wide_t v);
    if (v > Q48_MAX) begin
      return q48_t'(Q48_MAX);
    end else if (v < Q48_MIN) begin
      return q48_t'(Q48_MIN);
    end
    return q48_t'(v);
  endfunction

  // Fixed-point multiply: exact product, floor shift, clamp to 48 bits.
  function automatic q48_t fix_mul(q48_t a, logic signed [31:0] b);
    wide_t wa;
    wide_t wb;
    wa = a;
    wb = b;
    return clamp_q48((wa * wb) >>> FRAC_DEF);
  endfunction

  // Transform the eight corners, build outcodes and classify the box.
  function automatic vis_e predict_visibility(box_t b);
    logic signed [31:0] side [2][3];
    q48_t               mat [3][3];
    q48_t               shift [3];
    q48_t               term [2][3][3];
    logic signed [31:0] zx, zy, z_near, z_far;
    q48_t               cx, cy, cz;
    wide_t              wx, wy, wz;
    logic [5:0]         code, all_and, any_or;
    int                 a, bb, d;
    side[0][0] = b.min_x; side[0][1] = b.min_y; side[0][2] = b.min_z;
    side[1][0] = b.max_x; side[1][1] = b.max_y; side[1][2] = b.max_z;
    mat[0][0] = $signed(view_regs[REG_MAT_I_XY][31:0]);
    mat[0][1] = $signed(view_regs[REG_MAT_I_XY][63:32]);
    mat[0][2] = $signed(view_regs[REG_MAT_IZ_JX][31:0]);
    mat[1][0] = $signed(view_regs[REG_MAT_IZ_JX][63:32]);
    mat[1][1] = $signed(view_regs[REG_MAT_J_YZ][31:0]);
    mat[1][2] = $signed(view_regs[REG_MAT_J_YZ][63:32]);
    mat[2][0] = $signed(view_regs[REG_MAT_K_XY][31:0]);
    mat[2][1] = $signed(view_regs[REG_MAT_K_XY][63:32]);
    mat[2][2] = $signed(view_regs[REG_MAT_KZ_LX][31:0]);
    shift[0]  = $signed(view_regs[REG_MAT_KZ_LX][63:32]);
    shift[1]  = $signed(view_regs[REG_MAT_L_YZ][31:0]);
    shift[2]  = $signed(view_regs[REG_MAT_L_YZ][63:32]);
    zx     = $signed(view_regs[REG_ZOOM_XY][31:0]);
    zy     = $signed(view_regs[REG_ZOOM_XY][63:32]);
    z_near = $signed(view_regs[REG_CLIP_RANGE][31:0]);
    z_far  = $signed(view_regs[REG_CLIP_RANGE][63:32]);

    // Row terms per box side; the translation lands on the diagonal term.
    for (int s = 0; s < 2; s++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          term[s][r][c] = fix_mul(mat[r][c], side[s][r]);
          if (c == r) begin
            wx = term[s][r][c];
            wy = shift[r];
            term[s][r][c] = clamp_q48(wx + wy);
          end
        end
        term[s][r][0] = fix_mul(term[s][r][0], zx);
        term[s][r][1] = fix_mul(term[s][r][1], zy);
      end
    end

    // Each corner picks one side per axis.
    all_and = OC_ALL;
    any_or  = '0;
    for (int i = 0; i < 8; i++) begin
      a  = i & 1;
      bb = (i >> 1) & 1;
      d  = (i >> 2) & 1;
      wx = term[a][0][0];
      wx = wx + term[bb][1][0] + term[d][2][0];
      wy = term[a][0][1];
      wy = wy + term[bb][1][1] + term[d][2][1];
      wz = term[a][0][2];
      wz = wz + term[bb][1][2] + term[d][2][2];
      cx = clamp_q48(wx);
      cy = clamp_q48(wy);
      cz = clamp_q48(wz);
      wx = cx;
      wy = cy;
      wz = cz;
      code = '0;
      if (wx > wz) begin
        code |= OC_XPOS;
      end else if (wx < -wz) begin
        code |= OC_XNEG;
      end
      if (wy > wz) begin
        code |= OC_YPOS;
      end else if (wy < -wz) begin
        code |= OC_YNEG;
      end
      if (wz < z_near) begin
        code |= OC_NEAR;
      end else if (wz > z_far) begin
        code |= OC_FAR;
      end
      all_and &= code;
      any_or  |= code;
    end

    if (all_and != '0) begin
      return VIS_OUTSIDE;
    end else if (any_or == '0) begin
      return VIS_INSIDE;
    end
    return VIS_PARTIAL;
  endfunction

  // Random fixed-point value with a whole part in [lo, hi] and a random fraction.
  function automatic logic signed [31:0] rand_fix(int lo, int hi);
    int whole;
    whole = int'($urandom_range(hi - lo)) + lo;
    return (whole * (1 << FRAC_DEF)) + int'($urandom_range((1 << FRAC_DEF) - 1));
  endfunction

  function automatic box_t unit_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.min_x = x0 * ONE; b.min_y = y0 * ONE; b.min_z = z0 * ONE;
    b.max_x = x1 * ONE; b.max_y = y1 * ONE; b.max_z = z1 * ONE;
    return b;
  endfunction

  function automatic box_t fill_box(logic signed [31:0] lo, logic signed [31:0] hi);
    box_t b;
    b.min_x = lo; b.min_y = lo; b.min_z = lo;
    b.max_x = hi; b.max_y = hi; b.max_z = hi;
    return b;
  endfunction

  // Mostly boxes around the frustum; some with swapped corners, some raw noise.
  function automatic box_t make_box();
    box_t               b;
    logic signed [31:0] cx, cy, cz, ex, ey, ez;
    logic signed [31:0] t;
    if ($urandom_range(9) == 0) begin
      b.min_x = $urandom; b.min_y = $urandom; b.min_z = $urandom;
      b.max_x = $urandom; b.max_y = $urandom; b.max_z = $urandom;
      return b;
    end
    cx = rand_fix(-96, 95);
    cy = rand_fix(-96, 95);
    cz = rand_fix(-16, 95);
    ex = rand_fix(0, 23);
    ey = rand_fix(0, 23);
    ez = rand_fix(0, 23);
    b.min_x = cx - ex; b.max_x = cx + ex;
    b.min_y = cy - ey; b.max_y = cy + ey;
    b.min_z = cz - ez; b.max_z = cz + ez;
    if ($urandom_range(7) == 0) begin
      t = b.min_x; b.min_x = b.max_x; b.max_x = t;
    end
    if ($urandom_range(7) == 0) begin
      t = b.min_z; b.min_z = b.max_z; b.max_z = t;
    end
    return b;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (hold_req) begin
        out_stall_i = 1'b1;
        hold_left   = HOLD_CYCLES - 1;
        hold_req    = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result checker: every result beat is compared with the oldest expectation.
  always @(posedge clk_i) begin
    vis_e want;
    if (rst_ni && in_valid_i && in_stall_o) begin
      stall_offers++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_vis_q.size() == 0) begin
        $error("Unexpected result beat: visibility %0d", visibility_o);
        err_count++;
      end else begin
        want = expected_vis_q.pop_front();
        if (visibility_o !== want) begin
          $error("visibility mismatch: expected %0d, actual %0d", want, visibility_o);
          err_count++;
        end
        if (visibility_o <= VIS_INSIDE) begin
          class_count[visibility_o]++;
        end
      end
    end
  end

  // Send one box beat, idling beforehand at the current rate.
  task automatic send_box(box_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    box_min_x_i = b.min_x;
    box_min_y_i = b.min_y;
    box_min_z_i = b.min_z;
    box_max_x_i = b.max_x;
    box_max_y_i = b.max_y;
    box_max_z_i = b.max_z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_vis_q.push_back(predict_visibility(b));
    boxes_sent++;
  endtask

  // Stop offering boxes and wait until every result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_vis_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = REG_IDX_W'(idx);
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < NUM_REGS) begin
      view_regs[idx[REG_SEL_W-1:0]] = data;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_view(
    logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
    logic [31:0] jx, logic [31:0] jy, logic [31:0] jz,
    logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
    logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
    logic [31:0] zoom_x, logic [31:0] zoom_y,
    logic [31:0] z_near, logic [31:0] z_far
  );
    write_reg(REG_MAT_I_XY,   {iy, ix});
    write_reg(REG_MAT_IZ_JX,  {jx, iz});
    write_reg(REG_MAT_J_YZ,   {jz, jy});
    write_reg(REG_MAT_K_XY,   {ky, kx});
    write_reg(REG_MAT_KZ_LX,  {lx, kz});
    write_reg(REG_MAT_L_YZ,   {lz, ly});
    write_reg(REG_ZOOM_XY,    {zoom_y, zoom_x});
    write_reg(REG_CLIP_RANGE, {z_far, z_near});
    views_used++;
  endtask

  // Identity view, unit zoom, clip range from 1 to 64.
  task automatic set_plain_view();
    set_view(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, ONE, 64 * ONE);
  endtask

  task automatic set_random_view(view_kind_e kind);
    case (kind)
      VIEW_PLAIN: begin
        set_plain_view();
      end
      VIEW_SKEWED: begin
        set_view(rand_fix(-2, 1), rand_fix(-2, 1), rand_fix(-2, 1),
                 rand_fix(-2, 1), rand_fix(-2, 1), rand_fix(-2, 1),
                 rand_fix(-2, 1), rand_fix(-2, 1), rand_fix(-2, 1),
                 rand_fix(-16, 15), rand_fix(-16, 15), rand_fix(-16, 15),
                 rand_fix(0, 1), rand_fix(0, 1), rand_fix(0, 3), rand_fix(32, 159));
      end
      default: begin
        set_view(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE,
                 rand_fix(-24, 23), rand_fix(-24, 23), rand_fix(-8, 39),
                 rand_fix(0, 2), rand_fix(0, 2), rand_fix(0, 7), rand_fix(16, 199));
      end
    endcase
  endtask

  // After reset all registers are zero: every corner lands at the origin.
  task automatic test_reset_view();
    send_box(fill_box(FIX_MAX, FIX_MAX));
    send_box(fill_box(FIX_MIN, FIX_MIN));
    send_box(fill_box(FIX_MIN, FIX_MAX));
  endtask

  // Each clip plane on its own, inside, partial, swapped corners and extremes.
  task automatic test_directed_cases();
    box_t b;
    wait_drained();
    set_plain_view();
    send_box(unit_box(-1, -1, 10, 1, 1, 20));
    send_box(unit_box(30, -1, 10, 40, 1, 20));
    send_box(unit_box(-40, -1, 10, -30, 1, 20));
    send_box(unit_box(-1, 30, 10, 1, 40, 20));
    send_box(unit_box(-1, -40, 10, 1, -30, 20));
    send_box(unit_box(0, 0, -5, 0, 0, 0));
    send_box(unit_box(-1, -1, 70, 1, 1, 80));
    send_box(unit_box(-1, -1, 0, 1, 1, 10));
    send_box(unit_box(1, 1, 20, -1, -1, 10));
    send_box(unit_box(1, 1, 10, -1, -1, 0));
    send_box(fill_box(FIX_MAX, FIX_MAX));
    send_box(fill_box(FIX_MIN, FIX_MIN));
    send_box(fill_box(FIX_MIN, FIX_MAX));
    send_box(fill_box(0, 0));
    // Writes to indexes past the register file must leave the view untouched.
    wait_drained();
    write_reg(NUM_REGS + int'($urandom_range(NUM_REGS - 1)), {FIX_MIN, FIX_MAX});
    b = unit_box(-1, -1, 10, 1, 1, 20);
    send_box(b);
  endtask

  // Extreme register values drive the sums into saturation.
  task automatic test_saturation();
    logic [CFG_W-1:0] pattern [3];
    pattern[0] = {FIX_MAX, FIX_MAX};
    pattern[1] = {FIX_MIN, FIX_MIN};
    pattern[2] = '1;
    for (int p = 0; p < 3; p++) begin
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) begin
        write_reg(i, pattern[p]);
      end
      views_used++;
      send_box(fill_box(FIX_MIN, FIX_MAX));
      send_box(fill_box(FIX_MAX, FIX_MIN));
      for (int n = 0; n < 18; n++) begin
        send_box(make_box());
      end
    end
  endtask

  // Random boxes under every idling pattern and view kind.
  task automatic test_random_views();
    int idle_rate [4];
    int stall_rate [4];
    idle_rate  = '{0, 76, 0, 20};
    stall_rate = '{0, 0, 76, 20};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_rate[ph];
      stall_pct     = stall_rate[ph];
      for (int k = VIEW_PLAIN; k <= VIEW_ZOOMED; k++) begin
        wait_drained();
        set_random_view(view_kind_e'(k));
        for (int n = 0; n < RAND_BOXES; n++) begin
          send_box(make_box());
        end
      end
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall.
  task automatic test_backpressure();
    wait_drained();
    set_plain_view();
    send_idle_pct = 0;
    stall_pct     = 20;
    hold_req      = 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_box(make_box());
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    box_min_x_i   = '0;
    box_min_y_i   = '0;
    box_min_z_i   = '0;
    box_max_x_i   = '0;
    box_max_y_i   = '0;
    box_max_z_i   = '0;
    out_stall_i   = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    err_count     = 0;
    boxes_sent    = 0;
    views_used    = 0;
    stall_offers  = 0;
    class_count   = '{0, 0, 0};
    for (int i = 0; i < NUM_REGS; i++) begin
      view_regs[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_view();
    test_directed_cases();
    test_saturation();
    test_random_views();
    test_backpressure();

    wait_drained();
    repeat (2 * STAGES) @(posedge clk_i);
    $display("Checked %0d boxes over %0d views: %0d outside, %0d partial, %0d inside.",
             boxes_sent, views_used, class_count[VIS_OUTSIDE],
             class_count[VIS_PARTIAL], class_count[VIS_INSIDE]);
    $display("Box input was stalled for %0d offered cycles.", stall_offers);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", expected_vis_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
